// ----- sv/mpric_pkg.sv -----
// Package for the mesh point region classifier: field widths, request and
// region codes, register indexes and the micro-program of the shared multiplier.
// Depends on nothing; mpric_mul, the unit and the bench use it by scoped names.
`default_nettype none

package mpric_pkg;

    localparam int MAX_PARTICLES_DEF = 256;
    localparam int MAX_MATERIALS_DEF = 16;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int MAT_W   = 4;
    localparam int CFG_W   = 31;
    localparam int MASK_W  = 14;

    // Stream payload widths; the data widths are padded to whole bytes
    localparam int S_TDATA_W = 232;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 3;

    // Operand and product widths of the shift-add multiplier
    localparam int OPW = 68;
    localparam int PW  = 136;

    // Particle word layout, lowest field first
    localparam int PART_W = 6 * COORD_W + RAD_W + 1 + MAT_W;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_NODE  = 2'd1;
    localparam logic [1:0] REQ_ELEM  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] RGN_MATRIX = 2'd0;
    localparam logic [1:0] RGN_PISTON = 2'd1;
    localparam logic [1:0] RGN_HIT    = 2'd2;
    localparam logic [1:0] RGN_ACK    = 2'd3;

    localparam logic [1:0] CFG_LENGTH = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_PISTON = 2'd3;

    // Multiplier operand sources
    localparam logic [3:0] OP_ABX = 4'd0;
    localparam logic [3:0] OP_ABY = 4'd1;
    localparam logic [3:0] OP_ABZ = 4'd2;
    localparam logic [3:0] OP_APX = 4'd3;
    localparam logic [3:0] OP_APY = 4'd4;
    localparam logic [3:0] OP_APZ = 4'd5;
    localparam logic [3:0] OP_BPX = 4'd6;
    localparam logic [3:0] OP_BPY = 4'd7;
    localparam logic [3:0] OP_BPZ = 4'd8;
    localparam logic [3:0] OP_CX  = 4'd9;
    localparam logic [3:0] OP_CY  = 4'd10;
    localparam logic [3:0] OP_CZ  = 4'd11;
    localparam logic [3:0] OP_R   = 4'd12;
    localparam logic [3:0] OP_R2  = 4'd13;
    localparam logic [3:0] OP_AB2 = 4'd14;

    // Destinations of a finished accumulation
    localparam logic [3:0] D_NONE = 4'd0;
    localparam logic [3:0] D_C1   = 4'd1;
    localparam logic [3:0] D_C2   = 4'd2;
    localparam logic [3:0] D_AB2  = 4'd3;
    localparam logic [3:0] D_CX   = 4'd4;
    localparam logic [3:0] D_CY   = 4'd5;
    localparam logic [3:0] D_CZ   = 4'd6;
    localparam logic [3:0] D_CR2  = 4'd7;
    localparam logic [3:0] D_R2   = 4'd8;

    localparam int PC_W = 5;

    typedef struct packed {
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic       neg;
        logic       clr;
        logic [3:0] dest;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic start;
        logic neg;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    function automatic uop_t mk_uop(input logic [3:0] a, input logic [3:0] b,
                                    input logic neg, input logic clr,
                                    input logic [3:0] dest, input logic last);
        uop_t u;
        u.src_a = a;
        u.src_b = b;
        u.neg   = neg;
        u.clr   = clr;
        u.dest  = dest;
        u.last  = last;
        return u;
    endfunction

    // acc = (clr ? 0 : acc) +/- a*b, then store to dest
    function automatic uop_t uop_rom(input logic sphere, input logic [PC_W-1:0] pc);
        uop_t u;
        u = mk_uop(OP_R, OP_R, 1'b0, 1'b1, D_NONE, 1'b1);
        if (sphere) begin
            case (pc)
                5'd0: u = mk_uop(OP_APX, OP_APX, 1'b0, 1'b1, D_NONE, 1'b0);
                5'd1: u = mk_uop(OP_APY, OP_APY, 1'b0, 1'b0, D_NONE, 1'b0);
                5'd2: u = mk_uop(OP_APZ, OP_APZ, 1'b0, 1'b0, D_CR2,  1'b0);
                5'd3: u = mk_uop(OP_R,   OP_R,   1'b0, 1'b1, D_NONE, 1'b1);
                default: u = mk_uop(OP_R, OP_R, 1'b0, 1'b1, D_NONE, 1'b1);
            endcase
        end else begin
            case (pc)
                5'd0:  u = mk_uop(OP_ABX, OP_APX, 1'b0, 1'b1, D_NONE, 1'b0);
                5'd1:  u = mk_uop(OP_ABY, OP_APY, 1'b0, 1'b0, D_NONE, 1'b0);
                5'd2:  u = mk_uop(OP_ABZ, OP_APZ, 1'b0, 1'b0, D_C1,   1'b0);
                5'd3:  u = mk_uop(OP_ABX, OP_BPX, 1'b1, 1'b1, D_NONE, 1'b0);
                5'd4:  u = mk_uop(OP_ABY, OP_BPY, 1'b1, 1'b0, D_NONE, 1'b0);
                5'd5:  u = mk_uop(OP_ABZ, OP_BPZ, 1'b1, 1'b0, D_C2,   1'b0);
                5'd6:  u = mk_uop(OP_ABX, OP_ABX, 1'b0, 1'b1, D_NONE, 1'b0);
                5'd7:  u = mk_uop(OP_ABY, OP_ABY, 1'b0, 1'b0, D_NONE, 1'b0);
                5'd8:  u = mk_uop(OP_ABZ, OP_ABZ, 1'b0, 1'b0, D_AB2,  1'b0);
                5'd9:  u = mk_uop(OP_APY, OP_BPZ, 1'b0, 1'b1, D_NONE, 1'b0);
                5'd10: u = mk_uop(OP_APZ, OP_BPY, 1'b1, 1'b0, D_CX,   1'b0);
                5'd11: u = mk_uop(OP_APZ, OP_BPX, 1'b0, 1'b1, D_NONE, 1'b0);
                5'd12: u = mk_uop(OP_APX, OP_BPZ, 1'b1, 1'b0, D_CY,   1'b0);
                5'd13: u = mk_uop(OP_APX, OP_BPY, 1'b0, 1'b1, D_NONE, 1'b0);
                5'd14: u = mk_uop(OP_APY, OP_BPX, 1'b1, 1'b0, D_CZ,   1'b0);
                5'd15: u = mk_uop(OP_R,   OP_R,   1'b0, 1'b1, D_R2,   1'b0);
                5'd16: u = mk_uop(OP_CX,  OP_CX,  1'b0, 1'b1, D_NONE, 1'b0);
                5'd17: u = mk_uop(OP_CY,  OP_CY,  1'b0, 1'b0, D_NONE, 1'b0);
                5'd18: u = mk_uop(OP_CZ,  OP_CZ,  1'b0, 1'b0, D_CR2,  1'b0);
                5'd19: u = mk_uop(OP_R2,  OP_AB2, 1'b0, 1'b1, D_NONE, 1'b1);
                default: u = mk_uop(OP_R, OP_R, 1'b0, 1'b1, D_NONE, 1'b1);
            endcase
        end
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mpric_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module mpric_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/mpric_mul.sv -----
// Shift-add signed multiply-accumulate: result = init + (+/-a) * b, one bit of b per cycle.
// Depends on mpric_pkg.
`default_nettype none

module mpric_mul (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mpric_pkg::mul_req_t       req,
    input  wire logic [mpric_pkg::OPW-1:0] op_a,
    input  wire logic [mpric_pkg::OPW-1:0] op_b,
    input  wire logic [mpric_pkg::PW-1:0]  init,
    output mpric_pkg::mul_stat_t           stat,
    output logic      [mpric_pkg::PW-1:0]  result
);

    localparam int OPW   = mpric_pkg::OPW;
    localparam int PW    = mpric_pkg::PW;
    localparam int CNT_W = $clog2(OPW);

    logic [PW-1:0]    p_reg, m_reg;
    logic [OPW-1:0]   q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [OPW-1:0]   a_n;
    logic [PW-1:0]    addend, sum;
    logic             top_bit;

    assign top_bit = (cnt_reg == CNT_W'(OPW - 1));
    assign a_n     = req.neg ? (~op_a + OPW'(1)) : op_a;
    assign addend  = top_bit ? (~m_reg + PW'(1)) : m_reg;  // sign bit of b weighs negative
    assign sum     = p_reg + addend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (top_bit) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            p_reg <= init;
            m_reg <= {{(PW-OPW){a_n[OPW-1]}}, a_n};
            q_reg <= op_b;
        end else if (busy_reg) begin
            if (q_reg[0]) begin
                p_reg <= sum;
            end
            m_reg <= m_reg << 1;
            q_reg <= q_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = p_reg;

endmodule

`default_nettype wire

// ----- sv/mesh_point_region_classifier_unit.sv -----
// Mesh point region classifier. Load words append a cylinder or sphere with its
// material to a particle table in one RAM; clear words empty it. Classify words
// (node or element centroid, Q16.16) return piston when z is at or above
// box_height - piston_thickness, otherwise the material of the first stored
// particle that contains the point, otherwise matrix; node words also return
// the 14-bit boundary mask. One word is in work at a time; loads, clears,
// piston points and classifies on an empty table pass from the idle state
// through the result state to the output register. A classify walks the
// table in order, reading one particle at a time from the RAM and testing it
// on one shared 68-bit shift-add multiplier with a 136-bit accumulator: 20
// products per cylinder and 4 per sphere, stopping at the first hit.
// The table RAM is read only in the walk and written only as a load is taken,
// so the sequencer itself keeps the two apart. Configuration: cfg_we,
// cfg_addr (0 length, 1 width, 2 height, 3 piston thickness), cfg_wdata.
// Depends on mpric_pkg, mpric_ram and mpric_mul.
`default_nettype none

module mesh_point_region_classifier_unit #(
    parameter int MAX_PARTICLES = mpric_pkg::MAX_PARTICLES_DEF,
    parameter int MAX_MATERIALS = mpric_pkg::MAX_MATERIALS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // px, py, pz, end_bx, end_by, end_bz, radius, material_id, zero pad
    input  wire logic [mpric_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type, shape_kind
    input  wire logic [mpric_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // hit_material, boundary_mask, zero pad
    output logic      [mpric_pkg::M_TDATA_W-1:0] m_tdata,
    // region, table_full
    output logic      [mpric_pkg::M_TUSER_W-1:0] m_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_addr,
    input  wire logic [mpric_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW    = $clog2(MAX_PARTICLES + 1);
    localparam int OPW   = mpric_pkg::OPW;
    localparam int PW    = mpric_pkg::PW;
    localparam int CRD   = mpric_pkg::COORD_W;
    localparam int RAD_W = mpric_pkg::RAD_W;
    localparam int MAT_W = mpric_pkg::MAT_W;
    localparam int MSK_W = mpric_pkg::MASK_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_ISSUE  = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_EVAL   = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    // ---------------- configuration registers ----------------
    logic [mpric_pkg::CFG_W-1:0] len_reg, wid_reg, hgt_reg, pst_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            wid_reg <= '0;
            hgt_reg <= '0;
            pst_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                mpric_pkg::CFG_LENGTH: len_reg <= cfg_wdata;
                mpric_pkg::CFG_WIDTH:  wid_reg <= cfg_wdata;
                mpric_pkg::CFG_HEIGHT: hgt_reg <= cfg_wdata;
                mpric_pkg::CFG_PISTON: pst_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- input word fields ----------------
    logic [1:0]       in_req;
    logic             in_kind;
    logic [CRD-1:0]   in_px, in_py, in_pz, in_bx, in_by, in_bz;
    logic [RAD_W-1:0] in_rad;
    logic [MAT_W-1:0] in_mat;

    assign in_req  = s_tuser[1:0];
    assign in_kind = s_tuser[2];
    assign in_px   = s_tdata[31:0];
    assign in_py   = s_tdata[63:32];
    assign in_pz   = s_tdata[95:64];
    assign in_bx   = s_tdata[127:96];
    assign in_by   = s_tdata[159:128];
    assign in_bz   = s_tdata[191:160];
    assign in_rad  = s_tdata[222:192];
    assign in_mat  = s_tdata[226:223];

    // ---------------- control state ----------------
    logic [2:0]                state_reg;
    logic [CW-1:0]             count_reg;
    logic [AW-1:0]             idx_reg;
    logic [mpric_pkg::PC_W-1:0] pc_reg;
    logic                      m_tvalid_reg;

    logic s_accept, table_full, mat_ok, ram_we, piston, out_free;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign table_full = (count_reg == CW'(MAX_PARTICLES));
    assign mat_ok     = (32'(in_mat) < MAX_MATERIALS);
    assign ram_we     = s_accept && (in_req == mpric_pkg::REQ_LOAD) && !table_full && mat_ok;
    assign out_free   = !m_tvalid_reg || m_tready;

    // piston when z >= height - thickness, compared at 33 bits
    logic signed [CRD:0] z_ext, thr;
    assign z_ext  = $signed({in_pz[CRD-1], in_pz});
    assign thr    = $signed({2'b00, hgt_reg}) - $signed({2'b00, pst_reg});
    assign piston = (z_ext >= thr);

    // boundary groups: exact equality with the box faces
    logic [MSK_W-1:0] mask_c;
    logic x0, xl, y0, yw, z0, zh, xe, ye;
    always_comb begin
        x0 = (in_px == '0);
        xl = (in_px == {1'b0, len_reg});
        y0 = (in_py == '0);
        yw = (in_py == {1'b0, wid_reg});
        z0 = (in_pz == '0);
        zh = (in_pz == {1'b0, hgt_reg});
        xe = x0 || xl;
        ye = y0 || yw;
        mask_c = {yw && z0, y0 && z0, xl && z0, x0 && z0, xl && ye, x0 && ye,
                  xe && ye && zh, xe && ye && z0, yw, y0, xl, x0, z0, zh};
    end

    // ---------------- particle table ----------------
    logic [mpric_pkg::PART_W-1:0] ram_wdata, ram_rdata;

    assign ram_wdata = {in_mat, in_kind, in_rad, in_bz, in_by, in_bx, in_pz, in_py, in_px};

    mpric_ram #(
        .WIDTH (mpric_pkg::PART_W),
        .DEPTH (MAX_PARTICLES),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (state_reg == ST_READ),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // ---------------- working registers ----------------
    logic [CRD-1:0]   px_reg, py_reg, pz_reg;
    logic [CRD:0]     abx_reg, aby_reg, abz_reg, apx_reg, apy_reg, apz_reg;
    logic [CRD:0]     bpx_reg, bpy_reg, bpz_reg;
    logic [RAD_W-1:0] rad_reg;
    logic             kind_reg;
    logic [MAT_W-1:0] pmat_reg;
    logic [OPW-1:0]   cx_reg, cy_reg, cz_reg, r2_reg, ab2_reg;
    logic [PW-1:0]    cr2_reg, acc_reg;
    logic             c1_neg_reg, c2_neg_reg;

    // pending result and output register
    logic [1:0]       res_region;
    logic [MAT_W-1:0] res_mat;
    logic [MSK_W-1:0] res_mask;
    logic             res_full;
    logic [1:0]       out_region;
    logic [MAT_W-1:0] out_mat;
    logic [MSK_W-1:0] out_mask;
    logic             out_full;

    // unpack the stored particle
    logic [CRD-1:0] ra_x, ra_y, ra_z, rb_x, rb_y, rb_z;
    assign ra_x = ram_rdata[31:0];
    assign ra_y = ram_rdata[63:32];
    assign ra_z = ram_rdata[95:64];
    assign rb_x = ram_rdata[127:96];
    assign rb_y = ram_rdata[159:128];
    assign rb_z = ram_rdata[191:160];

    function automatic logic [CRD:0] sdiff(input logic [CRD-1:0] a, input logic [CRD-1:0] b);
        return {a[CRD-1], a} - {b[CRD-1], b};
    endfunction

    function automatic logic [OPW-1:0] sx(input logic [CRD:0] d);
        return {{(OPW-CRD-1){d[CRD]}}, d};
    endfunction

    // ---------------- multiplier ----------------
    mpric_pkg::uop_t      uop;
    mpric_pkg::mul_req_t  mreq;
    mpric_pkg::mul_stat_t mstat;
    logic [OPW-1:0]       op_a, op_b;
    logic [PW-1:0]        mul_init, mul_res;

    assign uop       = mpric_pkg::uop_rom(kind_reg, pc_reg);
    assign mreq.start = (state_reg == ST_ISSUE);
    assign mreq.neg   = uop.neg;
    assign mul_init   = uop.clr ? '0 : acc_reg;

    function automatic logic [OPW-1:0] pick(input logic [3:0] code,
        input logic [CRD:0] abx, input logic [CRD:0] aby, input logic [CRD:0] abz,
        input logic [CRD:0] apx, input logic [CRD:0] apy, input logic [CRD:0] apz,
        input logic [CRD:0] bpx, input logic [CRD:0] bpy, input logic [CRD:0] bpz,
        input logic [OPW-1:0] cx, input logic [OPW-1:0] cy, input logic [OPW-1:0] cz,
        input logic [RAD_W-1:0] r, input logic [OPW-1:0] r2, input logic [OPW-1:0] ab2);
        logic [OPW-1:0] v;
        case (code)
            mpric_pkg::OP_ABX: v = sx(abx);
            mpric_pkg::OP_ABY: v = sx(aby);
            mpric_pkg::OP_ABZ: v = sx(abz);
            mpric_pkg::OP_APX: v = sx(apx);
            mpric_pkg::OP_APY: v = sx(apy);
            mpric_pkg::OP_APZ: v = sx(apz);
            mpric_pkg::OP_BPX: v = sx(bpx);
            mpric_pkg::OP_BPY: v = sx(bpy);
            mpric_pkg::OP_BPZ: v = sx(bpz);
            mpric_pkg::OP_CX:  v = cx;
            mpric_pkg::OP_CY:  v = cy;
            mpric_pkg::OP_CZ:  v = cz;
            mpric_pkg::OP_R:   v = {{(OPW-RAD_W){1'b0}}, r};
            mpric_pkg::OP_R2:  v = r2;
            mpric_pkg::OP_AB2: v = ab2;
            default:           v = '0;
        endcase
        return v;
    endfunction

    assign op_a = pick(uop.src_a, abx_reg, aby_reg, abz_reg, apx_reg, apy_reg, apz_reg,
                       bpx_reg, bpy_reg, bpz_reg, cx_reg, cy_reg, cz_reg,
                       rad_reg, r2_reg, ab2_reg);
    assign op_b = pick(uop.src_b, abx_reg, aby_reg, abz_reg, apx_reg, apy_reg, apz_reg,
                       bpx_reg, bpy_reg, bpz_reg, cx_reg, cy_reg, cz_reg,
                       rad_reg, r2_reg, ab2_reg);

    mpric_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .op_a    (op_a),
        .op_b    (op_b),
        .init    (mul_init),
        .stat    (mstat),
        .result  (mul_res)
    );

    // containment: sphere d2 <= r2; cylinder inside both caps, axis not degenerate,
    // |AP x BP|^2 <= r2 * |AB|^2
    logic hit, last_entry;
    assign hit = (cr2_reg <= acc_reg) &&
                 (kind_reg || ((ab2_reg != '0) && !c1_neg_reg && !c2_neg_reg));
    assign last_entry = ((CW'(idx_reg) + CW'(1)) == count_reg);

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            pc_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // drop a taken word unless the result state reloads the register
            if (m_tready && (state_reg != ST_RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        case (in_req)
                            mpric_pkg::REQ_LOAD: begin
                                if (ram_we) begin
                                    count_reg <= count_reg + CW'(1);
                                end
                                state_reg <= ST_RESULT;
                            end
                            mpric_pkg::REQ_CLEAR: begin
                                count_reg <= '0;
                                state_reg <= ST_RESULT;
                            end
                            default: begin
                                idx_reg <= '0;
                                if (piston || (count_reg == '0)) begin
                                    state_reg <= ST_RESULT;
                                end else begin
                                    state_reg <= ST_READ;
                                end
                            end
                        endcase
                    end
                end
                ST_READ: state_reg <= ST_PREP;
                ST_PREP: begin
                    pc_reg    <= '0;
                    state_reg <= ST_ISSUE;
                end
                ST_ISSUE: state_reg <= ST_MUL;
                ST_MUL: begin
                    if (mstat.done) begin
                        if (uop.last) begin
                            state_reg <= ST_EVAL;
                        end else begin
                            pc_reg    <= pc_reg + mpric_pkg::PC_W'(1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_EVAL: begin
                    if (hit || last_entry) begin
                        state_reg <= ST_RESULT;
                    end else begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_RESULT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg   <= in_px;
            py_reg   <= in_py;
            pz_reg   <= in_pz;
            res_mat  <= '0;
            res_mask <= (in_req == mpric_pkg::REQ_NODE) ? mask_c : '0;
            res_full <= (in_req == mpric_pkg::REQ_LOAD) && table_full;
            case (in_req)
                mpric_pkg::REQ_LOAD, mpric_pkg::REQ_CLEAR: res_region <= mpric_pkg::RGN_ACK;
                default: res_region <= piston ? mpric_pkg::RGN_PISTON : mpric_pkg::RGN_MATRIX;
            endcase
        end
        if (state_reg == ST_PREP) begin
            abx_reg  <= sdiff(rb_x, ra_x);
            aby_reg  <= sdiff(rb_y, ra_y);
            abz_reg  <= sdiff(rb_z, ra_z);
            apx_reg  <= sdiff(px_reg, ra_x);
            apy_reg  <= sdiff(py_reg, ra_y);
            apz_reg  <= sdiff(pz_reg, ra_z);
            bpx_reg  <= sdiff(px_reg, rb_x);
            bpy_reg  <= sdiff(py_reg, rb_y);
            bpz_reg  <= sdiff(pz_reg, rb_z);
            rad_reg  <= ram_rdata[222:192];
            kind_reg <= ram_rdata[223];
            pmat_reg <= ram_rdata[227:224];
        end
        if ((state_reg == ST_MUL) && mstat.done) begin
            acc_reg <= mul_res;
            case (uop.dest)
                mpric_pkg::D_C1:  c1_neg_reg <= mul_res[PW-1];
                mpric_pkg::D_C2:  c2_neg_reg <= mul_res[PW-1];
                mpric_pkg::D_AB2: ab2_reg    <= mul_res[OPW-1:0];
                mpric_pkg::D_CX:  cx_reg     <= mul_res[OPW-1:0];
                mpric_pkg::D_CY:  cy_reg     <= mul_res[OPW-1:0];
                mpric_pkg::D_CZ:  cz_reg     <= mul_res[OPW-1:0];
                mpric_pkg::D_CR2: cr2_reg    <= mul_res;
                mpric_pkg::D_R2:  r2_reg     <= mul_res[OPW-1:0];
                default: ;
            endcase
        end
        if ((state_reg == ST_EVAL) && hit) begin
            res_region <= mpric_pkg::RGN_HIT;
            res_mat    <= pmat_reg;
        end
        if ((state_reg == ST_RESULT) && out_free) begin
            out_region <= res_region;
            out_mat    <= res_mat;
            out_mask   <= res_mask;
            out_full   <= res_full;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(mpric_pkg::M_TDATA_W-MSK_W-MAT_W){1'b0}}, out_mask, out_mat};
    assign m_tuser  = {out_full, out_region};

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PARTICLES))
        else $error("particle count beyond table depth");

    a_mul_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mreq.start |-> !mstat.busy)
        else $error("multiplier started while busy");

    a_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mstat.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the multiply state");

    a_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (s_accept && (state_reg == ST_IDLE)))
        else $error("table written outside an accepted load");

endmodule

`default_nettype wire

// ----- bench/mesh_point_region_classifier_unit_test.sv -----
// Self-checking bench for mesh_point_region_classifier_unit: a directed stimulus
// table, a table-full run and four register settings of random words.
// Depends on mpric_pkg and the block under test; checks typed verdicts, else its own predictor.
`default_nettype none

module mesh_point_region_classifier_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 256;
    localparam int STALL_LIMIT = 60000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    typedef struct {
        logic [1:0]         req;
        logic signed [31:0] px, py, pz, bx, by, bz;
        logic [30:0]        radius;
        logic               shape;
        logic [3:0]         mat;
    } word_t;

    typedef struct {
        logic [1:0]  region;
        logic [3:0]  mat;
        logic [13:0] mask;
        logic        full;
    } verdict_t;

    typedef struct {
        word_t    w;
        bit       known;
        verdict_t v;
    } row_t;

    typedef struct {
        logic signed [31:0] ax, ay, az, bx, by, bz;
        logic [30:0]        radius;
        logic               sphere;
        logic [3:0]         mat;
    } particle_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [mpric_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [mpric_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [mpric_pkg::M_TDATA_W-1:0] m_tdata;
    logic [mpric_pkg::M_TUSER_W-1:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = mpric_pkg::CFG_LENGTH;
    logic [mpric_pkg::CFG_W-1:0] cfg_wdata = '0;

    mesh_point_region_classifier_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Predictor state: box registers and the particle table
    logic [30:0] box_len, box_wid, box_hgt, piston_thk;
    particle_t   parts [TABLE_DEPTH];
    int          part_count;

    verdict_t pending_q [$];
    int       mismatches = 0;
    int       stall_cycles = 0;
    int       hold_cycles = 0;
    int       burst_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Exact containment test on squared magnitudes, wide enough for any operand
    function automatic bit particle_holds(int i, logic signed [31:0] x, y, z);
        logic signed [255:0] apx, apy, apz, bpx, bpy, bpz, abx, aby, abz;
        logic signed [255:0] r2, c1, c2, ab2, cx, cy, cz, cr2;
        particle_t p;
        p   = parts[i];
        apx = x - p.ax;
        apy = y - p.ay;
        apz = z - p.az;
        r2  = $signed({225'b0, p.radius}) * $signed({225'b0, p.radius});
        if (p.sphere)
            return apx * apx + apy * apy + apz * apz <= r2;
        bpx = x - p.bx;
        bpy = y - p.by;
        bpz = z - p.bz;
        abx = p.bx - p.ax;
        aby = p.by - p.ay;
        abz = p.bz - p.az;
        c1  = abx * apx + aby * apy + abz * apz;
        c2  = -(abx * bpx + aby * bpy + abz * bpz);
        ab2 = abx * abx + aby * aby + abz * abz;
        cx  = apy * bpz - apz * bpy;
        cy  = apz * bpx - apx * bpz;
        cz  = apx * bpy - apy * bpx;
        cr2 = cx * cx + cy * cy + cz * cz;
        if (ab2 == 0 || c1 < 0 || c2 < 0)
            return 1'b0;
        return cr2 <= r2 * ab2;
    endfunction

    function automatic logic [13:0] boundary_groups(logic signed [31:0] x, y, z);
        bit x0, xl, y0, yw, z0, zh, xe, ye;
        x0 = x == 0;
        xl = longint'(x) == longint'(box_len);
        y0 = y == 0;
        yw = longint'(y) == longint'(box_wid);
        z0 = z == 0;
        zh = longint'(z) == longint'(box_hgt);
        xe = x0 || xl;
        ye = y0 || yw;
        return {yw && z0, y0 && z0, xl && z0, x0 && z0, xl && ye, x0 && ye,
                xe && ye && zh, xe && ye && z0, yw, y0, xl, x0, z0, zh};
    endfunction

    // Advance the table and work out the verdict for one accepted word
    function automatic verdict_t classify_word(word_t w);
        verdict_t v;
        v = '{mpric_pkg::RGN_ACK, 4'd0, 14'd0, 1'b0};
        case (w.req)
            mpric_pkg::REQ_LOAD: begin
                if (part_count >= TABLE_DEPTH) begin
                    v.full = 1'b1;
                end else begin
                    parts[part_count] = '{w.px, w.py, w.pz, w.bx, w.by, w.bz,
                                          w.radius, w.shape, w.mat};
                    part_count++;
                end
            end
            mpric_pkg::REQ_CLEAR: part_count = 0;
            default: begin
                if (w.req == mpric_pkg::REQ_NODE)
                    v.mask = boundary_groups(w.px, w.py, w.pz);
                if (longint'(w.pz) >= longint'(box_hgt) - longint'(piston_thk)) begin
                    v.region = mpric_pkg::RGN_PISTON;
                end else begin
                    v.region = mpric_pkg::RGN_MATRIX;
                    for (int i = 0; i < part_count; i++) begin
                        if (particle_holds(i, w.px, w.py, w.pz)) begin
                            v.region = mpric_pkg::RGN_HIT;
                            v.mat    = parts[i].mat;
                            break;
                        end
                    end
                end
            end
        endcase
        return v;
    endfunction

    // Offer one word in the current burst; called at a falling edge
    task automatic send_word(input word_t w, input bit known, input verdict_t typed);
        verdict_t v, e;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 25) : 0) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid = 1'b1;
        s_tdata  = {5'b0, w.mat, w.radius, w.bz, w.by, w.bx, w.pz, w.py, w.px};
        s_tuser  = {w.shape, w.req};
        do @(posedge aclk); while (!s_tready);
        v = classify_word(w);
        if (known && v != typed)
            $display("predictor disagrees with typed verdict, row req %0d", w.req);
        e = known ? typed : v;
        pending_q = {pending_q, e};
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            mpric_pkg::CFG_LENGTH: box_len    = val;
            mpric_pkg::CFG_WIDTH:  box_wid    = val;
            mpric_pkg::CFG_HEIGHT: box_hgt    = val;
            default:               piston_thk = val;
        endcase
    endtask

    function automatic logic signed [31:0] near_coord();
        return $signed($urandom_range(0, 80 << 16)) - (40 <<< 16);
    endfunction

    function automatic logic signed [31:0] any_coord();
        return $urandom_range(0, 9) == 0 ? $signed($urandom) : near_coord();
    endfunction

    function automatic logic signed [31:0] pick_edge(logic [30:0] lim);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return $signed({1'b0, lim});
            2: return $signed($urandom);
            default: return near_coord();
        endcase
    endfunction

    // Random word: short tables, points mostly near stored particles or box faces
    function automatic word_t random_word();
        word_t w;
        int    roll, k;
        particle_t p;
        w = '{mpric_pkg::REQ_NODE, 0, 0, 0, 0, 0, 0, 31'd0, 1'b0, 4'd0};
        w.bx = $urandom;
        w.by = $urandom;
        w.bz = $urandom;
        w.radius = 31'($urandom);
        w.shape = 1'($urandom);
        w.mat = 4'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            w.req = part_count >= 3 ? mpric_pkg::REQ_CLEAR : mpric_pkg::REQ_LOAD;
            w.px = any_coord();
            w.py = any_coord();
            w.pz = any_coord();
            if ($urandom_range(0, 9) != 0) begin
                w.bx = w.px + near_coord() / 4;
                w.by = w.py + near_coord() / 4;
                w.bz = w.pz + near_coord() / 4;
                w.radius = 31'($urandom_range(0, 12 << 16));
            end
        end else if (roll < 36) begin
            w.req = mpric_pkg::REQ_CLEAR;
            w.px = $urandom;
            w.py = $urandom;
            w.pz = $urandom;
        end else begin
            w.req = $urandom_range(0, 1) ? mpric_pkg::REQ_NODE : mpric_pkg::REQ_ELEM;
            roll = $urandom_range(0, 99);
            if (roll < 45 && part_count > 0) begin
                k = $urandom_range(0, part_count - 1);
                p = parts[k];
                w.px = p.ax + near_coord() / 8;
                w.py = p.ay + near_coord() / 8;
                w.pz = p.az + near_coord() / 8;
                if (!p.sphere && $urandom_range(0, 1)) begin
                    w.px = p.ax + (p.bx - p.ax) / 2;
                    w.py = p.ay + (p.by - p.ay) / 2;
                    w.pz = p.az + (p.bz - p.az) / 2;
                end
            end else if (roll < 70) begin
                w.px = pick_edge(box_len);
                w.py = pick_edge(box_wid);
                w.pz = pick_edge(box_hgt);
            end else if (roll < 85) begin
                w.px = $urandom;
                w.py = $urandom;
                w.pz = $urandom;
            end else begin
                w.px = near_coord();
                w.py = near_coord();
                w.pz = near_coord();
            end
        end
        return w;
    endfunction

    function automatic row_t mk_row(logic [1:0] req, logic signed [31:0] x, y, z,
                                    logic signed [31:0] ex, ey, ez, logic [30:0] r,
                                    logic shape, logic [3:0] mat, bit known,
                                    logic [1:0] region, logic [13:0] mask);
        row_t row;
        row.w     = '{req, x, y, z, ex, ey, ez, r, shape, mat};
        row.known = known;
        row.v     = '{region, 4'd0, mask, 1'b0};
        return row;
    endfunction

    // Result checker: compare each taken word with the oldest expectation
    always @(posedge aclk) begin
        verdict_t exp_v, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser[1:0], m_tdata[3:0], m_tdata[17:4], m_tuser[2]};
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: region %0d mat %0d mask %h full %0d",
                             got.region, got.mat, got.mask, got.full);
            end else begin
                exp_v = pending_q.pop_front();
                if (got != exp_v) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp rgn %0d mat %0d mask %h full %0d, got %0d %0d %h %0d",
                                 exp_v.region, exp_v.mat, exp_v.mask, exp_v.full,
                                 got.region, got.mat, got.mask, got.full);
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a word
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: changing stall pattern, plus a long hold-off on request
    initial begin
        int mode, mode_left;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                hold_cycles--;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    initial begin
        row_t  rows [$];
        word_t w;
        logic [30:0] settings [4][4];
        logic [30:0] max31;

        max31 = 31'h7FFF_FFFF;
        box_len = '0;
        box_wid = '0;
        box_hgt = '0;
        piston_thk = '0;
        part_count = 0;

        // Registers at reset: every z from zero up is piston, negative z reaches the table
        rows = {rows, mk_row(mpric_pkg::REQ_NODE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                             mpric_pkg::RGN_PISTON, 14'h3FFF)};
        rows = {rows, mk_row(mpric_pkg::REQ_ELEM, 0, 0, -1, 0, 0, 0, 0, 0, 0, 1,
                             mpric_pkg::RGN_MATRIX, 14'h0)};
        rows = {rows, mk_row(mpric_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                             mpric_pkg::RGN_ACK, 14'h0)};
        rows = {rows, mk_row(mpric_pkg::REQ_NODE, 32'sh8000_0000, 32'sh8000_0000,
                             32'sh7FFF_FFFF, 0, 0, 0, 0, 0, 0, 1,
                             mpric_pkg::RGN_PISTON, 14'h0)};
        rows = {rows, mk_row(mpric_pkg::REQ_LOAD, 0, 0, -10 * ONE, 0, 0, 0, ONE, 1, 5,
                             1, mpric_pkg::RGN_ACK, 14'h0)};
        rows = {rows, mk_row(mpric_pkg::REQ_LOAD, 0, 0, -20 * ONE, 0, 0, -30 * ONE,
                             2 * ONE, 0, 9, 1, mpric_pkg::RGN_ACK, 14'h0)};
        // degenerate cylinder: both ends equal, never contains anything
        rows = {rows, mk_row(mpric_pkg::REQ_LOAD, 5 * ONE, 5 * ONE, -50 * ONE, 5 * ONE,
                             5 * ONE, -50 * ONE, max31, 0, 3, 1, mpric_pkg::RGN_ACK, 14'h0)};
        rows = {rows, mk_row(mpric_pkg::REQ_ELEM, 0, 0, -10 * ONE, 0, 0, 0, 0, 0, 0,
                             0, 0, 0)};
        rows = {rows, mk_row(mpric_pkg::REQ_ELEM, ONE, 0, -25 * ONE, 0, 0, 0, 0, 0, 0,
                             0, 0, 0)};
        rows = {rows, mk_row(mpric_pkg::REQ_ELEM, 5 * ONE, 5 * ONE, -50 * ONE, 0, 0, 0,
                             0, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(mpric_pkg::REQ_NODE, 0, 0, -20 * ONE, 0, 0, 0, 0, 0, 0,
                             0, 0, 0)};
        rows = {rows, mk_row(mpric_pkg::REQ_ELEM, 0, 0, -31 * ONE, 0, 0, 0, 0, 0, 0,
                             0, 0, 0)};
        rows = {rows, mk_row(mpric_pkg::REQ_LOAD, 32'sh8000_0000, 32'sh8000_0000,
                             32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                             32'sh7FFF_FFFF, max31, 1, 15, 1, mpric_pkg::RGN_ACK, 14'h0)};
        rows = {rows, mk_row(mpric_pkg::REQ_ELEM, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                             32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(mpric_pkg::REQ_ELEM, 32'sh8000_0000, 32'sh8000_0000, -1,
                             0, 0, 0, 0, 0, 0, 0, 0, 0)};
        rows = {rows, mk_row(mpric_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
                             mpric_pkg::RGN_ACK, 14'h0)};
        rows = {rows, mk_row(mpric_pkg::REQ_ELEM, 0, 0, -10 * ONE, 0, 0, 0, 0, 0, 0, 1,
                             mpric_pkg::RGN_MATRIX, 14'h0)};

        settings[0] = '{31'(10 * ONE), 31'(8 * ONE), 31'(100 * ONE), 31'(5 * ONE)};
        settings[1] = '{max31, max31, max31, max31};
        settings[2] = '{max31, max31, max31, 31'd0};
        settings[3] = '{31'(3 * ONE), 31'(2 * ONE), 31'(6 * ONE), max31};

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (rows[i])
            send_word(rows[i].w, rows[i].known, rows[i].v);

        for (int ph = 0; ph < 4; ph++) begin
            // hold the sender until every result is back, then reprogram the box
            drain_results();
            for (int r = 0; r < 4; r++)
                write_reg(r[1:0], settings[ph][r]);

            if (ph == 1) begin
                // fill the table to the brim; one more load is refused
                w = '{mpric_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 31'd0, 1'b0, 4'd0};
                send_word(w, 0, '{0, 0, 0, 0});
                for (int n = 0; n <= TABLE_DEPTH; n++) begin
                    w = random_word();
                    w.req = mpric_pkg::REQ_LOAD;
                    send_word(w, 0, '{0, 0, 0, 0});
                end
                w.req = mpric_pkg::REQ_NODE;
                w.pz = 32'sh7FFF_FFFF;
                send_word(w, 0, '{0, 0, 0, 0});
                w.req = mpric_pkg::REQ_CLEAR;
                send_word(w, 0, '{0, 0, 0, 0});
            end

            for (int n = 0; n < 400; n++) begin
                // long receiver hold-off while words keep being offered
                if (ph == 0 && n == 100)
                    hold_cycles = 3000;
                send_word(random_word(), 0, '{0, 0, 0, 0});
            end
        end

        drain_results();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
